// ----- rtl/core/bpfsp_pkg.sv -----
// Shared types, constants and helpers for the box packing free-space placer.
// Used by the space cell, the percentage divider and the top level.
// Depends on nothing else.
package bpfsp_pkg;

    localparam int DIM_BITS   = 12;
    localparam int MAX_SPACES = 64;
    localparam int IDX_W      = $clog2(MAX_SPACES);
    localparam int CNT_W      = $clog2(MAX_SPACES + 1);
    localparam int DIM2_W     = 2 * DIM_BITS;
    localparam int VOL_W      = 3 * DIM_BITS;
    localparam int VAL_W      = 32;
    localparam int BCNT_W     = 16;
    localparam int BVAL_W     = 16;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HGT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOXES = 3'd4;

    // Commands broadcast to the row of space cells.
    typedef logic [2:0] op_t;
    localparam op_t OP_HOLD   = 3'd0;
    localparam op_t OP_INIT   = 3'd1;
    localparam op_t OP_ROTATE = 3'd2;
    localparam op_t OP_DELETE = 3'd3;
    localparam op_t OP_INSERT = 3'd4;

    typedef logic [DIM_BITS-1:0] dim_t;

    typedef struct packed {
        dim_t z;
        dim_t y;
        dim_t x;
    } pt_t;

    typedef struct packed {
        logic valid;
        pt_t  org;
        pt_t  ext;
    } space_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        space_t           item;
    } cell_cmd_t;

    typedef struct packed {
        logic              first_of_order;
        dim_t              dim_a;
        dim_t              dim_b;
        dim_t              dim_c;
        logic [VOL_W-1:0]  box_volume;
        logic [BVAL_W-1:0] box_value;
        logic [2:0]        rotation;
    } box_word_t;

    typedef struct packed {
        logic              placed;
        logic              halted;
        dim_t              pos_x;
        dim_t              pos_y;
        dim_t              pos_z;
        dim_t              placed_len;
        dim_t              placed_wid;
        dim_t              placed_hgt;
        logic [BCNT_W-1:0] box_count;
        logic [PCT_W-1:0]  volume_pct;
        logic [PCT_W-1:0]  count_pct;
        logic [PCT_W-1:0]  value_pct;
    } result_word_t;

    // Sort key: length first, then height, then width.
    function automatic logic sorts_before(pt_t a, pt_t b);
        logic r;
        if (a.x != b.x) r = a.x < b.x;
        else if (a.z != b.z) r = a.z < b.z;
        else r = a.y < b.y;
        return r;
    endfunction

endpackage

// ----- rtl/core/bpfsp_cell.sv -----
// One slot of the sorted free-space list.
// Rotates, deletes and inserts together with its neighbors under a broadcast command.
// Depends on bpfsp_pkg.
module bpfsp_cell
    import bpfsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] slot,
    input  space_t           left,
    input  logic             left_open,
    input  space_t           right,
    output space_t           entry,
    output logic             open
);

    space_t entry_reg;
    space_t entry_next;

    // A slot is open for the new space when it is empty or holds a larger key.
    // The list is sorted, so the first open slot takes the new space and the
    // slots after it take their left neighbor.
    assign open  = !entry_reg.valid || sorts_before(cmd.item.ext, entry_reg.ext);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            OP_INIT:
            begin
                if (slot == '0) entry_next = cmd.item;
                else entry_next.valid = 1'b0;
            end
            OP_ROTATE: entry_next = right;
            OP_DELETE:
            begin
                if (slot >= cmd.idx) entry_next = right;
            end
            OP_INSERT:
            begin
                if (open) entry_next = left_open ? left : cmd.item;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) entry_reg <= '0;
        else entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/bpfsp_div.sv -----
// Percentage unit: min(100, num * 100 / den), 100 when den is zero.
// Restoring division, one quotient bit per cycle; a result that saturates at 100
// skips the division steps. Depends on bpfsp_pkg.
module bpfsp_div
    import bpfsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VOL_W-1:0] num,
    input  logic [VOL_W-1:0] den,
    output logic             done,
    output logic [PCT_W-1:0] quo
);

    localparam int QW = VOL_W + PCT_W;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CHK  = 2'd1;
    localparam logic [1:0] PH_STEP = 2'd2;

    logic [1:0]       ph_reg,   ph_next;
    logic [QW-1:0]    rem_reg,  rem_next;
    logic [QW-1:0]    hund_reg, hund_next;
    logic [VOL_W-1:0] den_reg,  den_next;
    logic [PCT_W-1:0] quo_reg,  quo_next;
    logic [2:0]       step_reg, step_next;
    logic             done_reg, done_next;
    logic [QW-1:0]    num_w, den_w, trial;

    assign num_w = QW'(num);
    assign den_w = QW'(den);
    assign trial = QW'(den_reg) << step_reg;
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_comb
    begin
        ph_next   = ph_reg;
        rem_next  = rem_reg;
        hund_next = hund_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        done_next = 1'b0;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    // Times 100 as 64 + 32 + 4.
                    rem_next  = (num_w << 6) + (num_w << 5) + (num_w << 2);
                    hund_next = (den_w << 6) + (den_w << 5) + (den_w << 2);
                    den_next  = den;
                    ph_next   = PH_CHK;
                end
            end
            PH_CHK:
            begin
                if (den_reg == '0 || rem_reg >= hund_reg)
                begin
                    quo_next  = PCT_FULL;
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
                else
                begin
                    quo_next  = '0;
                    step_next = 3'(PCT_W - 1);
                    ph_next   = PH_STEP;
                end
            end
            PH_STEP:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next           = rem_reg - trial;
                    quo_next[step_reg] = 1'b1;
                end
                if (step_reg == '0)
                begin
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
                else step_next = step_reg - 3'd1;
            end
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        hund_reg <= hund_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

endmodule

// ----- rtl/core/box_packing_free_space_placer.sv -----
// Box packing free-space placer: places one box per input word into the
// container and returns one result word per box.
// Input channel box_valid/box_stall/box_word, output channel
// result_valid/result_stall/result_word; a word moves at a clock edge with
// valid high and stall low. Configuration must be written through cfg_we,
// cfg_index and cfg_data while the block is idle; the block does not enforce it.
// Free spaces live in a row of MAX_SPACES cells kept sorted by size. Each box
// takes one full rotation of the row to find the first fitting space through
// the multiplier pipeline; the used space is then removed, the new spaces are
// inserted one after another, and the shared percentage divider makes three
// passes (volume, count, value), where a percentage that saturates at 100
// skips the division steps. The first box of an order first loads the whole
// container as the only space. A halted order's box skips search and update.
// One box is worked on at a time; box_stall is high while busy.
// The result sits in an output register, so a stalled receiver holds only
// that word; the next box is taken meanwhile but its result waits for the
// register to empty. Reset empties the list, clears the totals, halts the
// order until a word with first_of_order arrives, and sets the container to
// 4095 on each side and both divisors to one.
// Depends on bpfsp_pkg, bpfsp_cell and bpfsp_div.
module box_packing_free_space_placer
    import bpfsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  box_valid,
    output logic                  box_stall,
    input  box_word_t             box_word,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_word_t          result_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_DRAIN  = 4'd3;
    localparam logic [3:0] ST_EVAL   = 4'd4;
    localparam logic [3:0] ST_INS    = 4'd5;
    localparam logic [3:0] ST_PSTART = 4'd6;
    localparam logic [3:0] ST_PWAIT  = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    localparam logic [2:0] ROT_LWH = 3'd0;
    localparam logic [2:0] ROT_WLH = 3'd1;
    localparam logic [2:0] ROT_LHW = 3'd2;
    localparam logic [2:0] ROT_HLW = 3'd3;
    localparam logic [2:0] ROT_HWL = 3'd4;

    // Configuration registers.
    dim_t              clen_reg, cwid_reg, chgt_reg;
    logic [VAL_W-1:0]  tval_reg;
    logic [BCNT_W-1:0] tbox_reg;
    logic [DIM2_W-1:0] cv1_reg;
    logic [VOL_W-1:0]  cvol_reg;

    // Controller state.
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  sc_reg, sc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              halted_reg, halted_next;
    logic [VOL_W-1:0]  occ_reg, occ_next;
    logic [BCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [VAL_W-1:0]  pval_reg, pval_next;
    dim_t              l_reg, l_next, w_reg, w_next, h_reg, h_next;
    logic [VOL_W-1:0]  bvol_reg, bvol_next;
    logic [BVAL_W-1:0] bval_reg, bval_next;
    logic              found_reg, found_next;
    space_t            hit_reg, hit_next;
    logic [IDX_W-1:0]  hidx_reg, hidx_next;
    space_t            nsp_reg [3];
    space_t            nsp_next [3];
    logic [1:0]        k_reg, k_next;
    logic [1:0]        psel_reg, psel_next;
    result_word_t      res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    result_word_t      out_reg, out_next;

    // Fit test pipeline fed from the head cell during the rotation.
    logic              a_v_reg, b_v_reg;
    space_t            a_ent_reg, b_ent_reg;
    logic [IDX_W-1:0]  a_idx_reg, b_idx_reg;
    logic [DIM2_W-1:0] a_p1_reg;
    logic [VOL_W-1:0]  b_vol_reg;
    logic              fit;

    cell_cmd_t         cmd;
    space_t            ent [MAX_SPACES];
    logic              opn [MAX_SPACES];
    space_t            tail;

    space_t            cand [3];
    logic [1:0]        nn;
    logic [CNT_W:0]    need;
    logic [VOL_W:0]    occ_sum;
    logic [VAL_W:0]    pval_sum;
    dim_t              rl, rw, rh;

    logic              div_start, div_done;
    logic [VOL_W-1:0]  div_num, div_den;
    logic [PCT_W-1:0]  div_quo;

    logic              accept;

    assign box_stall    = state_reg != ST_IDLE;
    assign accept       = box_valid && !box_stall;
    assign result_valid = out_valid_reg;
    assign result_word  = out_reg;

    // The row of cells; the head cell feeds the tail during a rotation.
    assign tail = (cmd.op == OP_ROTATE) ? ent[0] : '0;

    for (genvar i = 0; i < MAX_SPACES; i++)
    begin : g_cell
        space_t left_i, right_i;
        logic   left_open_i;
        if (i == 0)
        begin : g_head
            assign left_i      = '0;
            assign left_open_i = 1'b0;
        end
        else
        begin : g_mid
            assign left_i      = ent[i-1];
            assign left_open_i = opn[i-1];
        end
        if (i == MAX_SPACES - 1)
        begin : g_last
            assign right_i = tail;
        end
        else
        begin : g_inner
            assign right_i = ent[i+1];
        end
        bpfsp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .slot      (IDX_W'(i)),
            .left      (left_i),
            .left_open (left_open_i),
            .right     (right_i),
            .entry     (ent[i]),
            .open      (opn[i])
        );
    end

    bpfsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Divider operand selection: volume, count, value.
    always_comb
    begin
        case (psel_reg)
            2'd0:
            begin
                div_num = occ_reg;
                div_den = cvol_reg;
            end
            2'd1:
            begin
                div_num = VOL_W'(pcnt_reg);
                div_den = VOL_W'(tbox_reg);
            end
            default:
            begin
                div_num = VOL_W'(pval_reg);
                div_den = VOL_W'(tval_reg);
            end
        endcase
    end

    assign div_start = state_reg == ST_PSTART;

    // Box orientation.
    always_comb
    begin
        case (box_word.rotation)
            ROT_LWH:
            begin
                rl = box_word.dim_a; rw = box_word.dim_b; rh = box_word.dim_c;
            end
            ROT_WLH:
            begin
                rw = box_word.dim_a; rl = box_word.dim_b; rh = box_word.dim_c;
            end
            ROT_LHW:
            begin
                rl = box_word.dim_a; rh = box_word.dim_b; rw = box_word.dim_c;
            end
            ROT_HLW:
            begin
                rh = box_word.dim_a; rl = box_word.dim_b; rw = box_word.dim_c;
            end
            ROT_HWL:
            begin
                rh = box_word.dim_a; rw = box_word.dim_b; rl = box_word.dim_c;
            end
            default:
            begin
                rw = box_word.dim_a; rh = box_word.dim_b; rl = box_word.dim_c;
            end
        endcase
    end

    assign fit = b_v_reg && b_vol_reg >= bvol_reg && b_ent_reg.ext.x >= l_reg
              && b_ent_reg.ext.y >= w_reg && b_ent_reg.ext.z >= h_reg;

    // Top, beside and front spaces left over by the chosen space.
    always_comb
    begin
        cand[0].org.x = hit_reg.org.x;
        cand[0].org.y = hit_reg.org.y;
        cand[0].org.z = hit_reg.org.z + h_reg;
        cand[0].ext.x = l_reg;
        cand[0].ext.y = w_reg;
        cand[0].ext.z = hit_reg.ext.z - h_reg;
        cand[1].org.x = hit_reg.org.x;
        cand[1].org.y = hit_reg.org.y + w_reg;
        cand[1].org.z = hit_reg.org.z;
        cand[1].ext.x = l_reg;
        cand[1].ext.y = hit_reg.ext.y - w_reg;
        cand[1].ext.z = hit_reg.ext.z;
        cand[2].org.x = hit_reg.org.x + l_reg;
        cand[2].org.y = hit_reg.org.y;
        cand[2].org.z = hit_reg.org.z;
        cand[2].ext.x = hit_reg.ext.x - l_reg;
        cand[2].ext.y = hit_reg.ext.y;
        cand[2].ext.z = hit_reg.ext.z;
        for (int k = 0; k < 3; k++)
        begin
            cand[k].valid = cand[k].ext.x != '0 && cand[k].ext.y != '0
                         && cand[k].ext.z != '0;
        end
        nn   = 2'(cand[0].valid) + 2'(cand[1].valid) + 2'(cand[2].valid);
        need = (CNT_W+1)'(count_reg) + (CNT_W+1)'(nn);
    end

    assign occ_sum  = (VOL_W+1)'(occ_reg) + (VOL_W+1)'(bvol_reg);
    assign pval_sum = (VAL_W+1)'(pval_reg) + (VAL_W+1)'(bval_reg);

    always_comb
    begin
        state_next     = state_reg;
        sc_next        = sc_reg;
        count_next     = count_reg;
        halted_next    = halted_reg;
        occ_next       = occ_reg;
        pcnt_next      = pcnt_reg;
        pval_next      = pval_reg;
        l_next         = l_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        bvol_next      = bvol_reg;
        bval_next      = bval_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        hidx_next      = hidx_reg;
        nsp_next       = nsp_reg;
        k_next         = k_reg;
        psel_next      = psel_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = OP_HOLD;

        if (out_valid_reg && !result_stall) out_valid_next = 1'b0;

        // Keep only the first fitting space seen in list order.
        if (fit && !found_reg)
        begin
            found_next = 1'b1;
            hit_next   = b_ent_reg;
            hidx_next  = b_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    l_next     = rl;
                    w_next     = rw;
                    h_next     = rh;
                    bvol_next  = box_word.box_volume;
                    bval_next  = box_word.box_value;
                    found_next = 1'b0;
                    sc_next    = '0;
                    psel_next  = '0;
                    res_next   = '0;
                    if (box_word.first_of_order) state_next = ST_INIT;
                    else if (halted_reg) state_next = ST_PSTART;
                    else state_next = ST_SCAN;
                end
            end
            ST_INIT:
            begin
                cmd.op         = OP_INIT;
                cmd.item.valid = 1'b1;
                cmd.item.org   = '0;
                cmd.item.ext.x = clen_reg;
                cmd.item.ext.y = cwid_reg;
                cmd.item.ext.z = chgt_reg;
                count_next     = CNT_W'(1);
                occ_next       = '0;
                pcnt_next      = '0;
                pval_next      = '0;
                halted_next    = 1'b0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.op = OP_ROTATE;
                if (sc_reg == CNT_W'(MAX_SPACES - 1))
                begin
                    sc_next    = '0;
                    state_next = ST_DRAIN;
                end
                else sc_next = sc_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                // The drain lets the last entries clear the multipliers.
                if (sc_reg == CNT_W'(1)) state_next = ST_EVAL;
                else sc_next = sc_reg + CNT_W'(1);
            end
            ST_EVAL:
            begin
                if (!found_reg || need > (CNT_W+1)'(MAX_SPACES + 1))
                begin
                    halted_next = 1'b1;
                    state_next  = ST_PSTART;
                end
                else
                begin
                    cmd.op     = OP_DELETE;
                    cmd.idx    = hidx_reg;
                    count_next = count_reg - CNT_W'(1);
                    nsp_next   = cand;
                    k_next     = '0;
                    occ_next   = occ_sum[VOL_W] ? '1 : occ_sum[VOL_W-1:0];
                    pval_next  = pval_sum[VAL_W] ? '1 : pval_sum[VAL_W-1:0];
                    if (pcnt_reg != '1) pcnt_next = pcnt_reg + BCNT_W'(1);
                    res_next.placed     = 1'b1;
                    res_next.pos_x      = hit_reg.org.x;
                    res_next.pos_y      = hit_reg.org.y;
                    res_next.pos_z      = hit_reg.org.z;
                    res_next.placed_len = l_reg;
                    res_next.placed_wid = w_reg;
                    res_next.placed_hgt = h_reg;
                    state_next          = ST_INS;
                end
            end
            ST_INS:
            begin
                // New spaces go in one a cycle, each after every equal key.
                if (nsp_reg[k_reg].valid)
                begin
                    cmd.op     = OP_INSERT;
                    cmd.item   = nsp_reg[k_reg];
                    count_next = count_reg + CNT_W'(1);
                end
                if (k_reg == 2'd2) state_next = ST_PSTART;
                else k_next = k_reg + 2'd1;
            end
            ST_PSTART: state_next = ST_PWAIT;
            ST_PWAIT:
            begin
                if (div_done)
                begin
                    case (psel_reg)
                        2'd0:    res_next.volume_pct = div_quo;
                        2'd1:    res_next.count_pct  = div_quo;
                        default: res_next.value_pct  = div_quo;
                    endcase
                    if (psel_reg == 2'd2) state_next = ST_FIN;
                    else
                    begin
                        psel_next  = psel_reg + 2'd1;
                        state_next = ST_PSTART;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next           = res_reg;
                    out_next.halted    = halted_reg;
                    out_next.box_count = pcnt_reg;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sc_reg        <= '0;
            count_reg     <= '0;
            halted_reg    <= 1'b1;
            occ_reg       <= '0;
            pcnt_reg      <= '0;
            pval_reg      <= '0;
            found_reg     <= 1'b0;
            k_reg         <= '0;
            psel_reg      <= '0;
            out_valid_reg <= 1'b0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            clen_reg      <= '1;
            cwid_reg      <= '1;
            chgt_reg      <= '1;
            tval_reg      <= VAL_W'(1);
            tbox_reg      <= BCNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            sc_reg        <= sc_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            occ_reg       <= occ_next;
            pcnt_reg      <= pcnt_next;
            pval_reg      <= pval_next;
            found_reg     <= found_next;
            k_reg         <= k_next;
            psel_reg      <= psel_next;
            out_valid_reg <= out_valid_next;
            a_v_reg       <= (state_reg == ST_SCAN) && ent[0].valid;
            b_v_reg       <= a_v_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LEN:   clen_reg <= cfg_data[DIM_BITS-1:0];
                    CFG_WID:   cwid_reg <= cfg_data[DIM_BITS-1:0];
                    CFG_HGT:   chgt_reg <= cfg_data[DIM_BITS-1:0];
                    CFG_VALUE: tval_reg <= cfg_data[VAL_W-1:0];
                    CFG_BOXES: tbox_reg <= cfg_data[BCNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg     <= l_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        bvol_reg  <= bvol_next;
        bval_reg  <= bval_next;
        hit_reg   <= hit_next;
        hidx_reg  <= hidx_next;
        nsp_reg   <= nsp_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        a_ent_reg <= ent[0];
        a_idx_reg <= sc_reg[IDX_W-1:0];
        a_p1_reg  <= DIM2_W'(ent[0].ext.x) * DIM2_W'(ent[0].ext.y);
        b_ent_reg <= a_ent_reg;
        b_idx_reg <= a_idx_reg;
        b_vol_reg <= VOL_W'(a_p1_reg) * VOL_W'(a_ent_reg.ext.z);
        // Container volume follows the configuration in two multiplier steps.
        cv1_reg   <= DIM2_W'(clen_reg) * DIM2_W'(cwid_reg);
        cvol_reg  <= VOL_W'(cv1_reg) * VOL_W'(chgt_reg);
    end

endmodule

// ----- sim/placer_checker.sv -----
// Checker for the box packing free-space placer: watches the box, result and
// configuration ports, predicts each result word and compares it field by field.
// Depends on bpfsp_pkg for the word types and register indexes.
module placer_checker
    import bpfsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  box_valid,
    input  logic                  box_stall,
    input  box_word_t             box_word,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_word_t          result_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] VOL_SAT = (64'd1 << VOL_W) - 1;
    localparam logic [63:0] VAL_SAT = 64'hFFFF_FFFF;

    dim_t              box_len_cfg, box_wid_cfg, box_hgt_cfg;
    logic [31:0]       value_total_cfg;
    logic [15:0]       boxes_total_cfg;

    pt_t               free_org [MAX_SPACES];
    pt_t               free_ext [MAX_SPACES];
    int                free_cnt;
    logic [63:0]       occupied, placed_boxes, placed_val;
    bit                order_stopped;

    result_word_t      expected_results[$];

    // Length first, then height, then width.
    function automatic bit extent_less(pt_t a, pt_t b);
        if (a.x != b.x)
            return a.x < b.x;
        if (a.z != b.z)
            return a.z < b.z;
        return a.y < b.y;
    endfunction

    function automatic logic [PCT_W-1:0] percent(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        if (den == 0)
            return PCT_W'(100);
        q = (num * 100) / den;
        return (q > 100) ? PCT_W'(100) : PCT_W'(q);
    endfunction

    function automatic bit nonempty(pt_t e);
        return e.x != 0 && e.y != 0 && e.z != 0;
    endfunction

    function automatic result_word_t place_box(box_word_t b);
        result_word_t r;
        dim_t         l, w, h;
        pt_t          o, e;
        pt_t          no [3];
        pt_t          ne [3];
        int           i, j, k, nn;
        bit           done;
        r = '0;
        done = 0;
        if (b.first_of_order)
        begin
            free_org[0] = '0;
            free_ext[0] = '{z: box_hgt_cfg, y: box_wid_cfg, x: box_len_cfg};
            free_cnt = 1;
            occupied = 0;
            placed_boxes = 0;
            placed_val = 0;
            order_stopped = 0;
        end
        case (b.rotation)
            3'd0: begin l = b.dim_a; w = b.dim_b; h = b.dim_c; end
            3'd1: begin w = b.dim_a; l = b.dim_b; h = b.dim_c; end
            3'd2: begin l = b.dim_a; h = b.dim_b; w = b.dim_c; end
            3'd3: begin h = b.dim_a; l = b.dim_b; w = b.dim_c; end
            3'd4: begin h = b.dim_a; w = b.dim_b; l = b.dim_c; end
            default: begin w = b.dim_a; h = b.dim_b; l = b.dim_c; end
        endcase
        if (!order_stopped)
        begin
            // Stable insertion sort keeps earlier entries ahead on ties.
            for (i = 1; i < free_cnt; i++)
            begin
                o = free_org[i];
                e = free_ext[i];
                j = i;
                while (j > 0 && extent_less(e, free_ext[j-1]))
                begin
                    free_org[j] = free_org[j-1];
                    free_ext[j] = free_ext[j-1];
                    j--;
                end
                free_org[j] = o;
                free_ext[j] = e;
            end
            for (i = 0; i < free_cnt; i++)
            begin
                o = free_org[i];
                e = free_ext[i];
                if (64'(e.x) * 64'(e.y) * 64'(e.z) >= 64'(b.box_volume)
                    && e.x >= l && e.y >= w && e.z >= h)
                begin
                    no[0] = '{z: o.z + h, y: o.y, x: o.x};
                    ne[0] = '{z: e.z - h, y: w, x: l};
                    no[1] = '{z: o.z, y: o.y + w, x: o.x};
                    ne[1] = '{z: e.z, y: e.y - w, x: l};
                    no[2] = '{z: o.z, y: o.y, x: o.x + l};
                    ne[2] = '{z: e.z, y: e.y, x: e.x - l};
                    nn = 0;
                    for (k = 0; k < 3; k++)
                        if (nonempty(ne[k]))
                            nn++;
                    if (free_cnt - 1 + nn > MAX_SPACES)
                        break;
                    for (j = i; j < free_cnt - 1; j++)
                    begin
                        free_org[j] = free_org[j+1];
                        free_ext[j] = free_ext[j+1];
                    end
                    free_cnt--;
                    for (k = 0; k < 3; k++)
                        if (nonempty(ne[k]))
                        begin
                            free_org[free_cnt] = no[k];
                            free_ext[free_cnt] = ne[k];
                            free_cnt++;
                        end
                    occupied = occupied + 64'(b.box_volume);
                    if (occupied > VOL_SAT)
                        occupied = VOL_SAT;
                    if (placed_boxes < 65535)
                        placed_boxes++;
                    placed_val = placed_val + 64'(b.box_value);
                    if (placed_val > VAL_SAT)
                        placed_val = VAL_SAT;
                    r.pos_x = o.x;
                    r.pos_y = o.y;
                    r.pos_z = o.z;
                    r.placed_len = l;
                    r.placed_wid = w;
                    r.placed_hgt = h;
                    done = 1;
                    break;
                end
            end
            if (!done)
                order_stopped = 1;
        end
        r.placed = done;
        r.halted = order_stopped;
        r.box_count = placed_boxes[15:0];
        r.volume_pct = percent(occupied,
                               64'(box_len_cfg) * 64'(box_wid_cfg) * 64'(box_hgt_cfg));
        r.count_pct = percent(placed_boxes, 64'(boxes_total_cfg));
        r.value_pct = percent(placed_val, 64'(value_total_cfg));
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: result field %s mismatch: expected %0d, got %0d",
                     $realtime, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            box_len_cfg = 12'd4095;
            box_wid_cfg = 12'd4095;
            box_hgt_cfg = 12'd4095;
            value_total_cfg = 32'd1;
            boxes_total_cfg = 16'd1;
            free_cnt = 0;
            occupied = 0;
            placed_boxes = 0;
            placed_val = 0;
            order_stopped = 1;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_LEN:   box_len_cfg = cfg_data[DIM_BITS-1:0];
                    CFG_WID:   box_wid_cfg = cfg_data[DIM_BITS-1:0];
                    CFG_HGT:   box_hgt_cfg = cfg_data[DIM_BITS-1:0];
                    CFG_VALUE: value_total_cfg = cfg_data;
                    CFG_BOXES: boxes_total_cfg = cfg_data[15:0];
                    default: ;
                endcase
            if (box_valid && !box_stall)
                expected_results.insert(expected_results.size(), place_box(box_word));
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: got %h",
                             $realtime, result_word);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("placed", 64'(want.placed), 64'(result_word.placed));
                    check_field("halted", 64'(want.halted), 64'(result_word.halted));
                    check_field("pos_x", 64'(want.pos_x), 64'(result_word.pos_x));
                    check_field("pos_y", 64'(want.pos_y), 64'(result_word.pos_y));
                    check_field("pos_z", 64'(want.pos_z), 64'(result_word.pos_z));
                    check_field("placed_len", 64'(want.placed_len),
                                64'(result_word.placed_len));
                    check_field("placed_wid", 64'(want.placed_wid),
                                64'(result_word.placed_wid));
                    check_field("placed_hgt", 64'(want.placed_hgt),
                                64'(result_word.placed_hgt));
                    check_field("box_count", 64'(want.box_count),
                                64'(result_word.box_count));
                    check_field("volume_pct", 64'(want.volume_pct),
                                64'(result_word.volume_pct));
                    check_field("count_pct", 64'(want.count_pct),
                                64'(result_word.count_pct));
                    check_field("value_pct", 64'(want.value_pct),
                                64'(result_word.value_pct));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the placer testbench: clock, reset, box and configuration stimulus,
// result-side stalling and the verdict.
// Depends on bpfsp_pkg, box_packing_free_space_placer and placer_checker.
module tb_top;
    import bpfsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 130;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  box_valid = 0;
    logic                  box_stall;
    box_word_t             box_word = '0;
    logic                  result_valid;
    logic                  result_stall = 0;
    result_word_t          result_word;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    bit                    hold_on = 0;
    int                    cycles = 0;

    box_packing_free_space_placer dut (.*);

    placer_checker u_checker (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(negedge clk)
        result_stall <= hold_on || ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called and returns at a falling edge.
    task automatic send_box(box_word_t w);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            box_valid = 0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 120 : 6))
                @(negedge clk);
        end
        box_valid = 1;
        box_word = w;
        do
            @(posedge clk);
        while (box_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        box_valid = 0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 0;
    endtask

    function automatic box_word_t make_box(bit first, int sz);
        box_word_t   w;
        logic [63:0] v;
        w.first_of_order = first;
        w.dim_a = DIM_BITS'($urandom_range(sz, 1));
        w.dim_b = DIM_BITS'($urandom_range(sz, 1));
        w.dim_c = DIM_BITS'($urandom_range(sz, 1));
        v = 64'(w.dim_a) * 64'(w.dim_b) * 64'(w.dim_c);
        case ($urandom_range(7))
            0: w.box_volume = VOL_W'({$urandom, $urandom}) | VOL_W'(1);
            1: w.box_volume = VOL_W'(v + 64'($urandom_range(3)));
            default: w.box_volume = VOL_W'(v);
        endcase
        w.box_value = BVAL_W'($urandom);
        w.rotation = 3'($urandom_range(7));
        return w;
    endfunction

    function automatic box_word_t fixed_box(bit first, int a, int b, int c,
                                            logic [63:0] vol, int rot);
        box_word_t w;
        w.first_of_order = first;
        w.dim_a = DIM_BITS'(a);
        w.dim_b = DIM_BITS'(b);
        w.dim_c = DIM_BITS'(c);
        w.box_volume = VOL_W'(vol);
        w.box_value = BVAL_W'($urandom);
        w.rotation = 3'(rot);
        return w;
    endfunction

    task automatic run_phase(int len, int wid, int hgt, logic [31:0] tval,
                             logic [15:0] tboxes, int idle, int stall,
                             int count, bit long_hold);
        int sent, n, sz, k, least;
        wait_drained();
        write_reg(CFG_LEN, CFG_DATA_W'(len));
        write_reg(CFG_WID, CFG_DATA_W'(wid));
        write_reg(CFG_HGT, CFG_DATA_W'(hgt));
        write_reg(CFG_VALUE, tval);
        write_reg(CFG_BOXES, CFG_DATA_W'(tboxes));
        idle_pct = idle;
        stall_pct = stall;
        least = (len < wid) ? len : wid;
        least = (hgt < least) ? hgt : least;
        if (long_hold)
            fork
                begin
                    hold_on = 1;
                    repeat (600) @(posedge clk);
                    hold_on = 0;
                end
            join_none
        sent = 0;
        while (sent < count)
        begin
            // Mostly boxes sized from the least side; at times a run of boxes of side
            // one or two that fills the space list, and at times an order with no start.
            if ($urandom_range(5) == 0 && least >= 8)
            begin
                sz = $urandom_range(2, 1);
                n = 75;
            end
            else
            begin
                sz = least / $urandom_range(1, 4);
                if (sz < 1)
                    sz = 1;
                n = $urandom_range(3, 30);
            end
            for (k = 0; k < n && sent < count; k++)
            begin
                send_box(make_box(k == 0 && $urandom_range(9) != 0, sz));
                sent++;
            end
        end
        stall_pct = 0;
    endtask

    initial
    begin
        int r;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed words against the reset container of 4095 on each side.
        send_box(fixed_box(0, 3, 3, 3, 27, 0));
        send_box(fixed_box(1, 4095, 4095, 4095, 64'hF_FFFF_FFFF, 0));
        send_box(fixed_box(1, 4095, 4095, 4095, 64'd68669157375, 0));
        send_box(fixed_box(0, 1, 1, 1, 1, 0));
        send_box(fixed_box(0, 1, 1, 1, 1, 0));
        for (r = 0; r < 8; r++)
            send_box(fixed_box(r == 0, 5, 7, 11, 385, r));
        send_box(fixed_box(0, 4095, 1, 1, 1, 1));
        send_box(fixed_box(0, 2, 2, 2, 1, 7));
        wait_drained();
        send_box(fixed_box(1, 100, 200, 300, 6000000, 3));

        run_phase(4095, 4095, 4095, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 120, 0);
        run_phase(1, 1, 1, 32'd1, 16'd1, 65, 0, 60, 0);
        run_phase(300, 17, 4095, 32'd1000, 16'd20, 0, 65, 130, 1);
        run_phase(4095, 1, 4095, 32'd50000, 16'd300, 13, 13, 130, 0);
        run_phase($urandom_range(4095, 1), $urandom_range(4095, 1),
                  $urandom_range(4095, 1), $urandom, 16'($urandom_range(65535, 1)),
                  0, 0, 130, 0);
        run_phase(4095, 4095, 4095, 32'd1, 16'd1, 65, 65, 130, 0);

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- box_packing_free_space_placer.f -----
rtl/core/bpfsp_pkg.sv
rtl/core/bpfsp_cell.sv
rtl/core/bpfsp_div.sv
rtl/core/box_packing_free_space_placer.sv
sim/placer_checker.sv
sim/tb_top.sv
